// ===== rtl/core/sfs_pkg.sv =====
// shared types and constants for the smallest factor sum block
`default_nettype none

package sfs_pkg;

  localparam int NUMBER_WIDTH_DEFAULT = 63;
  localparam int IN_TDATA_W           = 64;
  localparam int FACTOR_W             = 32;
  localparam int SUM_W                = 63;
  localparam int OUT_TDATA_W          = 96;
  localparam int KIND_W               = 2;
  localparam int QUEUE_DEPTH          = 2;

  // trial divisor sequence: 3, then 5, 7, 11, 13, ... in steps of 6
  localparam int FIRST_ODD_PRIME = 3;
  localparam int FIRST_CAND      = 5;
  localparam int CAND_PAIR_GAP   = 2;
  localparam int CAND_STEP       = 6;
  localparam int EVEN_FACTOR     = 2;

  // item kind decided at the front
  typedef enum logic [KIND_W-1:0] {
    KIND_TRIVIAL = 2'd0,
    KIND_EVEN    = 2'd1,
    KIND_ODD     = 2'd2
  } kind_t;

  // remainder unit status toward the sequencer
  typedef struct packed {
    logic done;
    logic divisible;
  } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/smallest_factor_sum_top.sv =====
// top level of the smallest factor sum block
// flow: 0..3 and even numbers go from the idle state to the emit state and on to the
//   output register; odd numbers first take one remainder by 3, and odd numbers that
//   are not multiples of 3 then try 6k-1 / 6k+1 candidate pairs, one remainder per
//   candidate, up to about sqrt(number) / 6 pairs
// the back end works on one item at a time; the front queue holds two items
// reset: synchronous, active high; clears the queue, sequencer, sum and flag
`default_nettype none

module smallest_factor_sum_top #(
  parameter int NUMBER_WIDTH = sfs_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // input item stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sfs_pkg::IN_TDATA_W-1:0]  s_tdata,   // [62:0] number, [63] zero pad
  // result item stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sfs_pkg::OUT_TDATA_W-1:0] m_tdata    // [31:0] smallest_factor,
                                                     // [94:32] running_sum,
                                                     // [95] sum_saturated
);
  import sfs_pkg::*;

  localparam int CAND_W  = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int ENTRY_W = KIND_W + NUMBER_WIDTH;

  // front end to queue
  logic                    f_push;
  kind_t                   f_kind;
  logic [NUMBER_WIDTH-1:0] f_number;
  logic                    q_full;
  logic                    q_empty;
  logic                    q_pop;
  logic [ENTRY_W-1:0]      q_data;
  kind_t                   q_kind;
  logic [NUMBER_WIDTH-1:0] q_number;

  // back end to remainder unit
  logic                    div_start;
  logic [NUMBER_WIDTH-1:0] div_dividend;
  logic [CAND_W-1:0]       div_divisor;
  div_status_t             div_status;

  // queue entries carry the kind above the masked number
  assign q_kind   = kind_t'(q_data[ENTRY_W-1 -: KIND_W]);
  assign q_number = q_data[NUMBER_WIDTH-1:0];

  // only the low NUMBER_WIDTH bits of the number are used
  sfs_front #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .number   (s_tdata[NUMBER_WIDTH-1:0]),
    .q_full   (q_full),
    .q_push   (f_push),
    .q_kind   (f_kind),
    .q_number (f_number)
  );

  // decouples intake from the long trial division loop
  sfs_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_kind, f_number}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // candidate walk, bound test, sum and output register
  sfs_back #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!q_empty),
    .q_kind       (q_kind),
    .q_number     (q_number),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_status   (div_status),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

  // computes one remainder at a time for the back end
  sfs_divider #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_status)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sfs_front.sv =====
// front end: takes items and sorts them into trivial, even and odd numbers
`default_nettype none

module sfs_front #(
  parameter int NUMBER_WIDTH = sfs_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [NUMBER_WIDTH-1:0] number,
  input  logic                    q_full,
  output logic                    q_push,
  output sfs_pkg::kind_t          q_kind,
  output logic [NUMBER_WIDTH-1:0] q_number
);
  import sfs_pkg::*;

  logic at_most_three;

  assign s_tready      = !q_full;
  assign q_push        = s_tvalid && !q_full;
  assign q_number      = number;
  // 0 through 3 have no factor to report
  assign at_most_three = (number[NUMBER_WIDTH-1:2] == '0);

  always_comb begin
    if (at_most_three) begin
      q_kind = KIND_TRIVIAL;
    end else if (!number[0]) begin
      q_kind = KIND_EVEN;
    end else begin
      q_kind = KIND_ODD;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfs_queue.sv =====
// short fifo between the front end and the trial division back end
`default_nettype none

module sfs_queue #(
  parameter int WIDTH = sfs_pkg::KIND_W + sfs_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import sfs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfs_divider.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none

module sfs_divider #(
  parameter int NUMBER_WIDTH = sfs_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [NUMBER_WIDTH-1:0]                dividend,
  input  logic [(NUMBER_WIDTH + 1) / 2 + 1 - 1:0] divisor,
  output sfs_pkg::div_status_t                   status
);
  import sfs_pkg::*;

  localparam int CAND_W = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int IDX_W  = $clog2(NUMBER_WIDTH);

  logic [NUMBER_WIDTH-1:0] dvd;
  logic [CAND_W-1:0]       dvs;
  logic [CAND_W-1:0]       rem;
  logic [IDX_W-1:0]        idx;
  logic                    busy;
  logic                    done;
  logic [CAND_W:0]         shifted;
  logic [CAND_W:0]         trial;

  assign shifted = {rem, dvd[idx]};
  assign trial   = shifted - {1'b0, dvs};

  assign status.done      = done;
  assign status.divisible = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        idx  <= IDX_W'(NUMBER_WIDTH - 1);
        busy <= 1'b1;
      end else if (busy) begin
        // keep the partial remainder when the subtract borrows
        rem <= trial[CAND_W] ? shifted[CAND_W-1:0] : trial[CAND_W-1:0];
        if (idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfs_back.sv =====
// back end: trial division sequencer, saturating sum and output register
`default_nettype none

module sfs_back #(
  parameter int NUMBER_WIDTH = sfs_pkg::NUMBER_WIDTH_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  input  sfs_pkg::kind_t                          q_kind,
  input  logic [NUMBER_WIDTH-1:0]                 q_number,
  output logic                                    q_pop,
  output logic                                    div_start,
  output logic [NUMBER_WIDTH-1:0]                 div_dividend,
  output logic [(NUMBER_WIDTH + 1) / 2 + 1 - 1:0] div_divisor,
  input  sfs_pkg::div_status_t                    div_status,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [sfs_pkg::OUT_TDATA_W-1:0]         m_tdata
);
  import sfs_pkg::*;

  localparam int CAND_W = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int SQ_W   = 2 * CAND_W;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_WAIT3   = 6'b000010,
    ST_BOUND   = 6'b000100,
    ST_WAIT_LO = 6'b001000,
    ST_WAIT_HI = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_t;

  state_t                  state;
  logic [NUMBER_WIDTH-1:0] num;
  logic [CAND_W-1:0]       cand;
  logic [SQ_W-1:0]         sq;
  logic [FACTOR_W-1:0]     factor;
  logic [SUM_W-1:0]        total;
  logic                    clipped;
  logic [FACTOR_W-1:0]     out_factor;
  logic [SUM_W-1:0]        out_sum;
  logic                    out_flag;

  logic [CAND_W-1:0]       cand_hi;
  logic [SQ_W-1:0]         sq_next;
  logic                    sq_ok;
  logic [SUM_W:0]          sum_wide;
  logic                    sum_over;
  logic [SUM_W-1:0]        total_next;
  logic                    out_ready;

  assign cand_hi = cand + CAND_W'(CAND_PAIR_GAP);
  // (c + 6)^2 = c^2 + 12c + 36
  assign sq_next = sq + (SQ_W'(cand) << 3) + (SQ_W'(cand) << 2)
                 + SQ_W'(CAND_STEP * CAND_STEP);
  assign sq_ok   = (sq <= SQ_W'(num));

  // total never exceeds 2^63-1 and the factor fits 32 bits, so no wrap
  assign sum_wide   = {1'b0, total} + (SUM_W + 1)'(factor);
  assign sum_over   = sum_wide[SUM_W];
  assign total_next = sum_over ? '1 : sum_wide[SUM_W-1:0];

  assign out_ready = !m_tvalid || m_tready;
  assign m_tdata   = {out_flag, out_sum, out_factor};

  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = num;
    div_divisor  = cand;
    unique case (state)
      ST_IDLE: begin
        q_pop        = q_valid;
        div_start    = q_valid && (q_kind == KIND_ODD);
        div_dividend = q_number;
        div_divisor  = CAND_W'(FIRST_ODD_PRIME);
      end
      ST_BOUND: begin
        div_start = sq_ok;
      end
      ST_WAIT_LO: begin
        div_start   = div_status.done && !div_status.divisible;
        div_divisor = cand_hi;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      total    <= '0;
      clipped  <= 1'b0;
    end else begin
      // in the emit state the output register is reloaded instead
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            num <= q_number;
            unique case (q_kind)
              KIND_ODD: begin
                state <= ST_WAIT3;
              end
              KIND_EVEN: begin
                factor <= FACTOR_W'(EVEN_FACTOR);
                state  <= ST_EMIT;
              end
              default: begin
                factor <= '0;
                state  <= ST_EMIT;
              end
            endcase
          end
        end
        ST_WAIT3: begin
          if (div_status.done) begin
            if (div_status.divisible) begin
              factor <= FACTOR_W'(FIRST_ODD_PRIME);
              state  <= ST_EMIT;
            end else begin
              cand  <= CAND_W'(FIRST_CAND);
              sq    <= SQ_W'(FIRST_CAND * FIRST_CAND);
              state <= ST_BOUND;
            end
          end
        end
        ST_BOUND: begin
          if (sq_ok) begin
            state <= ST_WAIT_LO;
          end else begin
            factor <= '0;
            state  <= ST_EMIT;
          end
        end
        ST_WAIT_LO: begin
          if (div_status.done) begin
            if (div_status.divisible) begin
              factor <= FACTOR_W'(cand);
              state  <= ST_EMIT;
            end else begin
              state <= ST_WAIT_HI;
            end
          end
        end
        ST_WAIT_HI: begin
          if (div_status.done) begin
            if (div_status.divisible) begin
              factor <= FACTOR_W'(cand_hi);
              state  <= ST_EMIT;
            end else begin
              cand  <= cand + CAND_W'(CAND_STEP);
              sq    <= sq_next;
              state <= ST_BOUND;
            end
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            total      <= total_next;
            clipped    <= clipped || sum_over;
            out_factor <= factor;
            out_sum    <= total_next;
            out_flag   <= clipped || sum_over;
            m_tvalid   <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfs_checker.sv =====
// port-level checks on the result stream, bound to the top level
`default_nettype none

module sfs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [sfs_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import sfs_pkg::*;

  localparam int SUM_LO = FACTOR_W;
  localparam int SUM_HI = FACTOR_W + SUM_W - 1;
  localparam int FLAG   = FACTOR_W + SUM_W;

  logic seen_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_sat <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[FLAG]) begin
      seen_sat <= 1'b1;
    end
  end

  // no result is offered right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // the saturation flag comes only with the sum at its ceiling
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[FLAG] |-> m_tdata[SUM_HI:SUM_LO] == '1)
    else $error("flag set below ceiling");

  // once saturated, every later result keeps the flag
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_sat |-> m_tdata[FLAG])
    else $error("saturation flag dropped");

endmodule

bind smallest_factor_sum_top sfs_checker u_checker (.*);

`default_nettype wire
